@@ hdl/sce_pkg.sv @@
// Shared types and constants of the stack command engine.
// No dependencies; imported by the stack cell and the top level.
`default_nettype none

package sce_pkg;

    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_DUMP = 3'd1;
    localparam logic [2:0] CMD_PEEK = 3'd2;
    localparam logic [2:0] CMD_POP  = 3'd3;
    localparam logic [2:0] CMD_SWAP = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_SHORT = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_PUSH  = 2'd1,
        CELL_SHIFT = 2'd2,
        CELL_SWAP  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] push_value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               has_value;
        status_t            status;
        logic               last;
    } out_t;

endpackage

`default_nettype wire

@@ hdl/sce_cell.sv @@
// One storage cell of the stack chain: holds a single entry.
// Depends on sce_pkg for the cell control struct.
`default_nettype none

module sce_cell
    import sce_pkg::*;
(
    input  wire logic               aclk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic signed [31:0] from_above,
    input  wire logic signed [31:0] from_below,
    input  wire logic signed [31:0] swap_in,
    output logic signed [31:0]      data
);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb begin
        case (ctrl.op)
            CELL_PUSH:  data_next = from_above;
            CELL_SHIFT: data_next = from_below;
            CELL_SWAP:  data_next = swap_in;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ hdl/stack_command_engine_unit.sv @@
// Top level of the stack command engine: control and the chain of stack cells.
// Depends on sce_pkg and sce_cell.
//
// Usage: commands enter on the s_ channel (valid/ready, payload in_t) and
// results leave on the m_ channel (valid/ready, payload out_t) from an output
// register. Push, peek, pop and swap each produce one result in the cycle
// after the request is accepted; a new request is taken every cycle while
// the output register is empty or being drained. The stack is a chain of
// STACK_DEPTH cells with the top in cell zero. A dump rotates the whole
// chain once, emitting the occupied entries top first on the first steps;
// intake is closed for the whole rotation, which pauses on an emitting step
// while the receiver stalls the output. A dump of an empty stack gives a
// single result without a value. Unknown commands are accepted and
// produce no result.
// When the receiver holds m_ready low, the output register keeps its result
// and s_ready stays low until the result is taken.
// Reset (aresetn low, synchronous) empties the stack and the output
// register; cell contents are not cleared.
`default_nettype none

module stack_command_engine_unit
    import sce_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;
    cell_op_t            chain_op;
    cell_ctrl_t          cell_ctrl [STACK_DEPTH];
    logic signed [31:0]  cell_data [STACK_DEPTH];
    logic                out_free;
    logic                accept;
    logic                emit_step;

    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign emit_step = CNT_W'(step_reg) < count_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        chain_op       = CELL_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_data_next.result_value = '0;
                    out_data_next.has_value    = 1'b0;
                    out_data_next.status       = STATUS_OK;
                    out_data_next.last         = 1'b1;
                    out_valid_next             = 1'b1;
                    case (s_data.command)
                        CMD_PUSH: begin
                            if (count_reg == CNT_W'(STACK_DEPTH)) begin
                                out_data_next.status = STATUS_FULL;
                            end else begin
                                chain_op   = CELL_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DUMP: begin
                            if (count_reg != '0) begin
                                out_valid_next = 1'b0;
                                state_next     = ST_DUMP;
                                step_next      = '0;
                            end
                        end
                        CMD_PEEK: begin
                            if (count_reg == '0) begin
                                out_data_next.status = STATUS_EMPTY;
                            end else begin
                                out_data_next.result_value = cell_data[0];
                                out_data_next.has_value    = 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (count_reg == '0) begin
                                out_data_next.status = STATUS_EMPTY;
                            end else begin
                                chain_op   = CELL_SHIFT;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_SWAP: begin
                            if (count_reg < CNT_W'(2)) begin
                                out_data_next.status = STATUS_SHORT;
                            end else begin
                                chain_op = CELL_SWAP;
                            end
                        end
                        default: begin
                            out_valid_next = out_valid_reg && !m_ready;
                        end
                    endcase
                end
            end
            ST_DUMP: begin
                if (!emit_step || out_free) begin
                    chain_op = CELL_SHIFT;
                    if (emit_step) begin
                        out_valid_next             = 1'b1;
                        out_data_next.result_value = cell_data[0];
                        out_data_next.has_value    = 1'b1;
                        out_data_next.status       = STATUS_OK;
                        out_data_next.last         = (CNT_W'(step_reg) + 1'b1) == count_reg;
                    end
                    if (step_reg == STEP_W'(STACK_DEPTH - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic signed [31:0] above_w;
        logic signed [31:0] below_w;
        logic signed [31:0] swap_w;

        if (i == 0) begin : g_top
            assign above_w = s_data.push_value;
            assign swap_w  = cell_data[1];
        end else begin : g_inner
            assign above_w = cell_data[i-1];
            assign swap_w  = cell_data[0];
        end

        if (i == STACK_DEPTH - 1) begin : g_wrap
            assign below_w = cell_data[0];
        end else begin : g_link
            assign below_w = cell_data[i+1];
        end

        if (i < 2) begin : g_swap_op
            assign cell_ctrl[i].op = chain_op;
        end else begin : g_plain_op
            assign cell_ctrl[i].op = (chain_op == CELL_SWAP) ? CELL_HOLD : chain_op;
        end

        sce_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .from_above (above_w),
            .from_below (below_w),
            .swap_in    (swap_w),
            .data       (cell_data[i])
        );
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count exceeds depth");

    a_dump_closes_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> !s_ready)
        else $error("request taken during dump");

    a_dump_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |=> $stable(count_reg))
        else $error("stack count changed during dump");

    a_dump_ends_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP && state_next == ST_IDLE)
            |-> step_reg == STEP_W'(STACK_DEPTH - 1))
        else $error("dump left before a full rotation");

endmodule

`default_nettype wire

@@ verif/sce_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the stack command engine: watches both channels, keeps its own stack
// to predict each result, and compares what leaves the block. Depends on sce_pkg.
module sce_result_checker
    import sce_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_ready,
    input  wire in_t  s_data,
    input  wire logic m_valid,
    input  wire logic m_ready,
    input  wire out_t m_data,
    output int        failures,
    output int        results_pending
);

    logic signed [31:0] entries [STACK_DEPTH];
    int                 occupancy;
    out_t               expected_results [$];

    function automatic out_t make_result(logic signed [31:0] value, logic has,
                                         status_t st, logic fin);
        out_t r;
        r.result_value = value;
        r.has_value    = has;
        r.status       = st;
        r.last         = fin;
        return r;
    endfunction

    task automatic apply_command(input in_t req);
        logic signed [31:0] held;
        int                 i;
        case (req.command)
            CMD_PUSH: begin
                if (occupancy >= STACK_DEPTH) begin
                    expected_results.push_back(make_result('0, 1'b0, STATUS_FULL, 1'b1));
                end else begin
                    entries[occupancy] = req.push_value;
                    occupancy++;
                    expected_results.push_back(make_result('0, 1'b0, STATUS_OK, 1'b1));
                end
            end
            CMD_DUMP: begin
                if (occupancy == 0) begin
                    expected_results.push_back(make_result('0, 1'b0, STATUS_OK, 1'b1));
                end else begin
                    for (i = occupancy; i > 0; i--) begin
                        expected_results.push_back(
                            make_result(entries[i - 1], 1'b1, STATUS_OK, i == 1));
                    end
                end
            end
            CMD_PEEK: begin
                if (occupancy == 0) begin
                    expected_results.push_back(make_result('0, 1'b0, STATUS_EMPTY, 1'b1));
                end else begin
                    expected_results.push_back(
                        make_result(entries[occupancy - 1], 1'b1, STATUS_OK, 1'b1));
                end
            end
            CMD_POP: begin
                if (occupancy == 0) begin
                    expected_results.push_back(make_result('0, 1'b0, STATUS_EMPTY, 1'b1));
                end else begin
                    occupancy--;
                    expected_results.push_back(make_result('0, 1'b0, STATUS_OK, 1'b1));
                end
            end
            CMD_SWAP: begin
                if (occupancy < 2) begin
                    expected_results.push_back(make_result('0, 1'b0, STATUS_SHORT, 1'b1));
                end else begin
                    held = entries[occupancy - 1];
                    entries[occupancy - 1] = entries[occupancy - 2];
                    entries[occupancy - 2] = held;
                    expected_results.push_back(make_result('0, 1'b0, STATUS_OK, 1'b1));
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic note_failure(input string what, input out_t want, input out_t got);
        failures++;
        if (failures <= 10) begin
            $display("%s: expected value %0d has %0b status %0d last %0b,",
                     what, want.result_value, want.has_value, want.status, want.last,
                     " got value %0d has %0b status %0d last %0b",
                     got.result_value, got.has_value, got.status, got.last);
        end
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (expected_results.size() == 0) begin
            note_failure("unexpected result", '0, got);
        end else begin
            want = expected_results.pop_front();
            if (got.result_value !== want.result_value || got.has_value !== want.has_value
                    || got.status !== want.status || got.last !== want.last) begin
                note_failure("result mismatch", want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            occupancy = 0;
            expected_results.delete();
            failures = 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (s_valid && s_ready) begin
                apply_command(s_data);
            end
        end
        results_pending = expected_results.size();
    end

endmodule

@@ verif/stack_command_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// Top of the stack command engine testbench: clock, reset, request stimulus and verdict.
// Depends on sce_pkg, stack_command_engine_unit and sce_result_checker.
module stack_command_engine_unit_tb;
    import sce_pkg::*;

    localparam int         STACK_DEPTH     = 64;
    localparam int         TAIL_CYCLES     = STACK_DEPTH + 8;
    localparam int         HOLD_CYCLES     = 4 * STACK_DEPTH;
    localparam int         RANDOM_REQUESTS = 220;
    localparam int         PHASE_COUNT     = 4;
    localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int failures;
    int results_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int fill_guess     = 0;

    stack_command_engine_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    sce_result_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .failures       (failures),
        .results_pending(results_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("stack_command_engine_unit verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holds_served <= hold_requests;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_command(int target);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return 3'($urandom_range(CMD_RESERVED_LAST, CMD_RESERVED_FIRST));
        if (roll < 7) return CMD_DUMP;
        if (roll < 17) return CMD_PEEK;
        if (roll < 29) return CMD_SWAP;
        if (fill_guess < target) return (roll < 80) ? CMD_PUSH : CMD_POP;
        return (roll < 80) ? CMD_POP : CMD_PUSH;
    endfunction

    task automatic send_request(input logic [2:0] cmd, input logic signed [31:0] value);
        in_t req;
        req.command    = cmd;
        req.push_value = value;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_PUSH && fill_guess < STACK_DEPTH) begin
            fill_guess++;
        end else if (cmd == CMD_POP && fill_guess > 0) begin
            fill_guess--;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (results_pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          phase;
        int          sent;
        int          target;
        int          k;
        logic [2:0]  cmd;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty stack, single entry, extreme values, reserved codes, and popping past empty.
        send_request(CMD_PEEK, random_value());
        send_request(CMD_POP, random_value());
        send_request(CMD_SWAP, random_value());
        send_request(CMD_DUMP, random_value());
        send_request(CMD_PUSH, 32'h7fff_ffff);
        send_request(CMD_SWAP, '0);
        send_request(CMD_PEEK, '1);
        send_request(CMD_PUSH, 32'h8000_0000);
        send_request(CMD_PUSH, '0);
        send_request(CMD_PUSH, '1);
        send_request(CMD_PEEK, '0);
        send_request(CMD_SWAP, '1);
        send_request(CMD_DUMP, '0);
        send_request(CMD_POP, '1);
        send_request(CMD_POP, '0);
        send_request(CMD_PEEK, '0);
        send_request(CMD_DUMP, '1);
        for (k = CMD_RESERVED_FIRST; k <= CMD_RESERVED_LAST; k++) begin
            send_request(k[2:0], random_value());
        end
        send_request(CMD_POP, '0);
        send_request(CMD_POP, '0);
        send_request(CMD_POP, '1);

        // Fill the stack to the top and one push beyond it.
        for (k = 0; k <= STACK_DEPTH; k++) begin
            send_request(CMD_PUSH, random_value());
        end
        send_request(CMD_SWAP, random_value());
        send_request(CMD_PEEK, random_value());
        send_request(CMD_DUMP, random_value());
        wait_idle();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 72;
                end
                default: begin
                    send_idle_pct = 23;
                    recv_stall_pct <= 23;
                end
            endcase
            if (phase == 0 || phase == 3) begin
                hold_requests <= hold_requests + 1;
                for (k = 0; k < 24; k++) begin
                    send_request(($urandom_range(1) != 0) ? CMD_PUSH : CMD_PEEK,
                                 random_value());
                end
            end
            sent = 0;
            target = $urandom_range(STACK_DEPTH);
            while (sent < RANDOM_REQUESTS / PHASE_COUNT) begin
                if (sent % 30 == 0) begin
                    case ($urandom_range(5))
                        0: target = 0;
                        1: target = 1;
                        2: target = 2;
                        3: target = STACK_DEPTH - 1;
                        4: target = STACK_DEPTH + 1;
                        default: target = $urandom_range(STACK_DEPTH);
                    endcase
                end
                if (sent == RANDOM_REQUESTS / (2 * PHASE_COUNT)) begin
                    wait_idle();
                end
                cmd = pick_command(target);
                send_request(cmd, random_value());
                if (cmd < CMD_RESERVED_FIRST) begin
                    sent++;
                end
            end
            wait_idle();
        end

        if (failures == 0 && results_pending == 0) begin
            $display("stack_command_engine_unit verification clean");
        end else begin
            $display("stack_command_engine_unit verification failed");
        end
        $finish;
    end

endmodule
